// File: hw/rtl/fwdf_pkg.sv
// Shared types and constants of the fixed-width decimal formatter.
package fwdf_pkg;

    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned COUNT_W  = 4;
    localparam int unsigned POINT_W  = 2;
    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned DIGIT_W  = 4;
    localparam int unsigned NDIGITS  = 10;
    localparam int unsigned S_DATA_W = 40;
    localparam int unsigned STEP_W   = 34;

    localparam logic [COUNT_W-1:0] MAX_DIGITS = 4'd10;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0]  CHAR_POINT = 8'h2E;

    // Place values of the ten decimal positions, wide enough for nine times the top one.
    localparam logic [STEP_W-1:0] POW10 [NDIGITS] = '{
        34'd1, 34'd10, 34'd100, 34'd1000, 34'd10000, 34'd100000,
        34'd1000000, 34'd10000000, 34'd100000000, 34'd1000000000
    };

    // One converted number, handed from the front to the back.
    typedef struct packed {
        logic [CHAR_W-1:0]                lead_char;
        logic                             ovf;
        logic [COUNT_W-1:0]               ndig;
        logic [POINT_W-1:0]               point;
        logic [NDIGITS-1:0][DIGIT_W-1:0]  digits;
    } rec_t;

endpackage

// File: hw/rtl/fwdf_front.sv
// Front part: accepts a number and converts it to decimal digits, one digit per cycle.
module fwdf_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [fwdf_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                            push_valid,
    input  logic                            push_ready,
    output fwdf_pkg::rec_t                  push_rec
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_CONV = 3'b010,
        F_PUSH = 3'b100
    } front_state_t;

    front_state_t state_reg, state_next;
    logic [fwdf_pkg::VALUE_W-1:0]  rem_reg, rem_next;
    logic [3:0]                    pos_reg, pos_next;
    logic [fwdf_pkg::COUNT_W-1:0]  ndig_reg, ndig_next;
    logic [fwdf_pkg::POINT_W-1:0]  point_reg, point_next;
    logic [fwdf_pkg::CHAR_W-1:0]   acc_reg, acc_next;
    logic                          ovf_reg, ovf_next;
    logic [fwdf_pkg::NDIGITS-1:0][fwdf_pkg::DIGIT_W-1:0] digits_reg, digits_next;

    logic [fwdf_pkg::VALUE_W-1:0]  in_value;
    logic [fwdf_pkg::COUNT_W-1:0]  in_count;
    logic [fwdf_pkg::POINT_W-1:0]  in_point;

    logic [fwdf_pkg::STEP_W-1:0]   pow_sel;
    logic [fwdf_pkg::STEP_W-1:0]   thr;
    logic [fwdf_pkg::STEP_W-1:0]   thr_sel;
    logic [fwdf_pkg::DIGIT_W-1:0]  digit;

    assign in_value = s_tdata[31:0];
    assign in_count = s_tdata[35:32];
    assign in_point = s_tdata[37:36];

    // The remainder is always below ten times the current place value, so the
    // digit is the largest multiple that still fits.
    always_comb begin
        pow_sel = fwdf_pkg::POW10[pos_reg];
        digit   = '0;
        thr_sel = '0;
        thr     = '0;
        for (int k = 1; k <= 9; k++) begin
            thr = pow_sel * fwdf_pkg::STEP_W'(k);
            if ({2'b00, rem_reg} >= thr) begin
                digit   = fwdf_pkg::DIGIT_W'(k);
                thr_sel = thr;
            end
        end
    end

    always_comb begin
        state_next  = state_reg;
        rem_next    = rem_reg;
        pos_next    = pos_reg;
        ndig_next   = ndig_reg;
        point_next  = point_reg;
        acc_next    = acc_reg;
        ovf_next    = ovf_reg;
        digits_next = digits_reg;
        s_tready    = 1'b0;
        push_valid  = 1'b0;
        unique case (state_reg)
            F_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    rem_next   = in_value;
                    pos_next   = 4'(fwdf_pkg::NDIGITS - 1);
                    ndig_next  = (in_count == '0 || in_count > fwdf_pkg::MAX_DIGITS)
                               ? fwdf_pkg::MAX_DIGITS : in_count;
                    point_next = in_point;
                    acc_next   = '0;
                    ovf_next   = 1'b0;
                    state_next = F_CONV;
                end
            end
            F_CONV: begin
                digits_next[pos_reg] = digit;
                // Positions at and above the leading one fold into its quotient,
                // kept modulo 256 as the character truncates it anyway.
                if (({1'b0, pos_reg} + 5'd1) >= {1'b0, ndig_reg}) begin
                    acc_next = 8'(acc_reg * 8'd10) + {4'b0000, digit};
                end
                if (pos_reg >= ndig_reg && digit != '0) begin
                    ovf_next = 1'b1;
                end
                rem_next = rem_reg - thr_sel[fwdf_pkg::VALUE_W-1:0];
                if (pos_reg == '0) begin
                    state_next = F_PUSH;
                end else begin
                    pos_next = pos_reg - 4'd1;
                end
            end
            F_PUSH: begin
                push_valid = 1'b1;
                if (push_ready) begin
                    state_next = F_IDLE;
                end
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    assign push_rec.lead_char = fwdf_pkg::CHAR_ZERO + acc_reg;
    assign push_rec.ovf       = ovf_reg;
    assign push_rec.ndig      = ndig_reg;
    assign push_rec.point     = point_reg;
    assign push_rec.digits    = digits_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg    <= rem_next;
        pos_reg    <= pos_next;
        ndig_reg   <= ndig_next;
        point_reg  <= point_next;
        acc_reg    <= acc_next;
        ovf_reg    <= ovf_next;
        digits_reg <= digits_next;
    end

endmodule

// File: hw/rtl/fwdf_queue.sv
// Short queue of converted numbers between the front and the back.
module fwdf_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push_valid,
    output logic            push_ready,
    input  fwdf_pkg::rec_t  push_rec,
    output logic            pop_valid,
    input  logic            pop,
    output fwdf_pkg::rec_t  pop_rec
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    fwdf_pkg::rec_t mem [DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;
    assign pop_rec    = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

// File: hw/rtl/fwdf_back.sv
// Back part: walks one converted number and sends its characters, one word per cycle while m_tready holds.
module fwdf_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           rec_valid,
    input  fwdf_pkg::rec_t                 rec,
    output logic                           rec_pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [fwdf_pkg::CHAR_W-1:0]    m_tdata,
    output logic                           m_tlast,
    output logic                           m_tuser
);

    typedef enum logic [5:0] {
        B_IDLE = 6'b000001,
        B_ZERO = 6'b000010,
        B_LDOT = 6'b000100,
        B_LEAD = 6'b001000,
        B_DOT  = 6'b010000,
        B_DIG  = 6'b100000
    } back_state_t;

    back_state_t state_reg, state_next;
    logic [3:0]                  pos_reg, pos_next;
    logic                        out_valid_reg, out_valid_next;
    logic [fwdf_pkg::CHAR_W-1:0] char_reg, char_next;
    logic                        last_reg, last_next;
    logic                        ovf_reg, ovf_next;

    logic                        load;
    logic                        emit;
    logic [fwdf_pkg::CHAR_W-1:0] ch;
    logic                        ch_last;

    // The output register takes a new word when it is empty or being drained.
    assign load = !out_valid_reg || m_tready;

    always_comb begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg && !m_tready;
        char_next      = char_reg;
        last_next      = last_reg;
        ovf_next       = ovf_reg;
        rec_pop        = 1'b0;
        emit           = 1'b0;
        ch             = fwdf_pkg::CHAR_ZERO;
        ch_last        = 1'b0;
        unique case (state_reg)
            B_IDLE: begin
                if (rec_valid) begin
                    state_next = (rec.point != '0 && {2'b00, rec.point} == rec.ndig)
                               ? B_ZERO : B_LEAD;
                end
            end
            B_ZERO: begin
                if (load) begin
                    emit       = 1'b1;
                    ch         = fwdf_pkg::CHAR_ZERO;
                    state_next = B_LDOT;
                end
            end
            B_LDOT: begin
                if (load) begin
                    emit       = 1'b1;
                    ch         = fwdf_pkg::CHAR_POINT;
                    state_next = B_LEAD;
                end
            end
            B_LEAD: begin
                if (load) begin
                    emit = 1'b1;
                    ch   = rec.lead_char;
                    if (rec.ndig == 4'd1) begin
                        ch_last    = 1'b1;
                        state_next = B_IDLE;
                    end else begin
                        pos_next   = rec.ndig - 4'd2;
                        state_next = ({2'b00, rec.point} == rec.ndig - 4'd1) ? B_DOT : B_DIG;
                    end
                end
            end
            B_DOT: begin
                if (load) begin
                    emit       = 1'b1;
                    ch         = fwdf_pkg::CHAR_POINT;
                    state_next = B_DIG;
                end
            end
            B_DIG: begin
                if (load) begin
                    emit = 1'b1;
                    ch   = fwdf_pkg::CHAR_ZERO + {4'b0000, rec.digits[pos_reg]};
                    if (pos_reg == '0) begin
                        ch_last    = 1'b1;
                        state_next = B_IDLE;
                    end else begin
                        pos_next   = pos_reg - 4'd1;
                        // The point goes before the digit whose position is one below it.
                        state_next = ({2'b00, rec.point} == pos_reg) ? B_DOT : B_DIG;
                    end
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase

        if (emit) begin
            out_valid_next = 1'b1;
            char_next      = ch;
            last_next      = ch_last;
            ovf_next       = rec.ovf;
            rec_pop        = ch_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = char_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = ovf_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg  <= pos_next;
        char_reg <= char_next;
        last_reg <= last_next;
        ovf_reg  <= ovf_next;
    end

endmodule

// File: hw/rtl/fixed_width_decimal_formatter.sv
// Top level of the fixed-width decimal formatter: front, queue, back and checks.
//
//  Channel  Dir  Handshake           Contents
//  s_       in   s_tvalid/s_tready   one number with its digit count and point position
//  m_       out  m_tvalid/m_tready   one ASCII character, tlast on the final one
//
// The front takes a number in F_IDLE, converts it in F_CONV (one digit per cycle,
// largest place value first) and hands the result to the queue in F_PUSH, so it takes
// no new number until the last one is handed to the queue.
// The back picks up a queued number in B_IDLE and then sends one character per cycle
// while m_tready holds, at most eleven, so it keeps pace with the front's digit loop.
// Reset is synchronous and active low; it empties the queue and the output register.
// A stalled output only fills the queue; the front stalls once the queue is full.

module fixed_width_decimal_formatter #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // s_tdata fields from bit 0: value[31:0], digit_count[35:32],
    // point_position[37:36], zero fill [39:38].
    input  logic [fwdf_pkg::S_DATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata fields from bit 0: character[7:0].
    output logic [fwdf_pkg::CHAR_W-1:0]   m_tdata,
    output logic                          m_tlast,
    // m_tuser fields from bit 0: overflow.
    output logic                          m_tuser
);

    logic           q_push_valid;
    logic           q_push_ready;
    fwdf_pkg::rec_t q_push_rec;
    logic           q_pop_valid;
    logic           q_pop;
    fwdf_pkg::rec_t q_pop_rec;

    // Front: takes the number and converts it into the digit record.
    fwdf_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_rec   (q_push_rec)
    );

    // Queue: lets a converted number wait while the output is stalled.
    fwdf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_rec   (q_push_rec),
        .pop_valid  (q_pop_valid),
        .pop        (q_pop),
        .pop_rec    (q_pop_rec)
    );

    // Back: sends the leading zero when needed, the point and the digits in order.
    fwdf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rec_valid (q_pop_valid),
        .rec       (q_pop_rec),
        .rec_pop   (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // The front works on one number at a time, so it is busy right after taking one.
    a_front_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("front accepted a word while converting");

    // Without overflow every character is a digit or the point.
    a_char_set: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |->
        ((m_tdata >= fwdf_pkg::CHAR_ZERO && m_tdata <= 8'h39) ||
         m_tdata == fwdf_pkg::CHAR_POINT))
        else $error("unexpected character in a number without overflow");

    // Within a number the back refills the output register without a gap.
    a_no_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
        else $error("gap inside a number");

    // A record is only popped when the queue holds one.
    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_pop_valid)
        else $error("pop from an empty queue");

endmodule
